// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

    // Default sizing
    localparam int MAX_CHUNKS_DEF   = 1024;
    localparam int ORDER_LEVELS_DEF = 11;

    // Opcodes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    // Register indexes
    localparam logic [3:0] REG_CHUNK_LOG2 = 4'd0;
    localparam logic [3:0] REG_HEADER     = 4'd1;
    localparam logic [3:0] REG_TOP_ORDER  = 4'd2;
    localparam logic [3:0] REG_POOL_BASE  = 4'd3;

    // Register reset values and limits
    localparam logic [4:0]  CHUNK_RST = 5'd9;
    localparam logic [7:0]  HDR_RST   = 8'd8;
    localparam logic [3:0]  TOP_RST   = 4'd10;
    localparam logic [31:0] BASE_RST  = 32'd0;
    localparam logic [4:0]  CHUNK_MAX = 5'd20;

    // Datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT,
        CMD_SIZE_START,
        CMD_K_INC,
        CMD_SEARCH_START,
        CMD_SEARCH_STEP,
        CMD_SPLIT_START,
        CMD_SPLIT_STEP,
        CMD_ALLOC_DONE,
        CMD_FREE_START,
        CMD_FREE_READ,
        CMD_FREE_ORDER,
        CMD_MERGE_STEP,
        CMD_FREE_DONE,
        CMD_FAIL_SIZE,
        CMD_FAIL_SPACE,
        CMD_FAIL_FREE,
        CMD_NOP,
        CMD_PUSH
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      in_ready;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] opcode;
        logic       req_zero;
        logic       k_fits;
        logic       k_at_top;
        logic       row_any;
        logic       o_at_top;
        logic       o_gt_k;
        logic       free_bad;
        logic       buddy_avail;
        logic       o_lt_top;
        logic       out_free;
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SIZE,
        S_SEARCH,
        S_SPLIT0,
        S_SPLIT,
        S_FCHK,
        S_FRD,
        S_MERGE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/bba_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [30:0] request_bytes;
    logic [31:0] release_address;
    modport source (output valid, output opcode, output request_bytes,
                    output release_address, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input release_address, output ready);
endinterface

interface bba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] user_address;
    logic [3:0]  block_order;
    modport source (output valid, output status, output user_address,
                    output block_order, input ready);
    modport sink   (input valid, input status, input user_address,
                    input block_order, output ready);
endinterface

interface bba_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bba_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_dp #(
    parameter int MAX_CHUNKS   = bba_pkg::MAX_CHUNKS_DEF,
    parameter int ORDER_LEVELS = bba_pkg::ORDER_LEVELS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bba_in_if.sink            in_ch,
    bba_out_if.source         out_ch,
    bba_cfg_if.sink           cfg,
    input  bba_pkg::cmd_t     cmd,
    output bba_pkg::sts_t     sts
);
    import bba_pkg::*;

    localparam int IW      = $clog2(MAX_CHUNKS);
    localparam int NCH     = 2 ** IW;
    localparam int LW      = $clog2(ORDER_LEVELS);
    localparam int CAP     = $clog2(MAX_CHUNKS + 1) - 1;
    localparam int TOP_LIM = (ORDER_LEVELS - 1 < CAP) ? ORDER_LEVELS - 1 : CAP;
    localparam logic [3:0] RST_TOP = (int'(TOP_RST) > TOP_LIM) ? 4'(TOP_LIM) : TOP_RST;

    // Configuration registers
    logic [4:0]  chunk_reg;
    logic [7:0]  hdr_reg;
    logic [3:0]  top_reg;
    logic [31:0] base_reg;

    // Working registers
    logic [1:0]    op_reg;
    logic [30:0]   req_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   need_reg;
    logic [3:0]    k_reg;
    logic [3:0]    o_reg;
    logic [IW-1:0] idx_reg;
    logic          bad_reg;
    logic [3:0]    live_top_reg;

    // Free bitmaps, one row per order; allocation marks
    logic [NCH-1:0] free_reg [ORDER_LEVELS];
    logic [NCH-1:0] av_reg;

    // Order of each live allocation
    logic [3:0] ord_mem [NCH];
    logic [3:0] ord_q_reg;

    // Result and output stage
    logic [1:0]  res_status_reg;
    logic [31:0] res_addr_reg;
    logic [3:0]  res_order_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_addr_reg;
    logic [3:0]  out_order_reg;

    // Lowest set bit of a bitmap row
    function automatic logic [IW-1:0] lowest(input logic [NCH-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = NCH - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    logic [3:0]     eff_top;
    logic [4:0]     eff_c;
    logic [35:0]    blk_bytes;
    logic [31:0]    need_sum;
    logic [31:0]    chunk32;
    logic [31:0]    need_next;
    logic [NCH-1:0] row;
    logic [IW-1:0]  enc;
    logic [31:0]    off;
    logic [31:0]    idx_full;
    logic           range_bad;
    logic           align_bad;
    logic [3:0]     om1;
    logic [IW-1:0]  bit_o;
    logic [IW-1:0]  split_idx;
    logic [IW-1:0]  buddy;
    logic [31:0]    user_addr;
    logic [3:0]     ord_clip;

    // Effective limits
    always_comb
    begin
        eff_top = (int'(top_reg) > TOP_LIM) ? 4'(TOP_LIM) : top_reg;
        eff_c   = (chunk_reg > CHUNK_MAX) ? CHUNK_MAX : chunk_reg;
    end

    // Size rounding and search
    assign blk_bytes = 36'(1) << (6'(eff_c) + 6'(k_reg));
    assign need_sum  = 32'(req_reg) + 32'(hdr_reg);
    assign chunk32   = 32'(1) << eff_c;
    assign need_next = (need_sum < chunk32) ? chunk32 : need_sum;
    assign row       = free_reg[LW'(o_reg)];
    assign enc       = lowest(row);

    // Free address translation
    assign off       = addr_reg - 32'(hdr_reg) - base_reg;
    assign idx_full  = off >> eff_c;
    assign range_bad = (idx_full >> live_top_reg) != 32'd0;
    assign align_bad = (off & (chunk32 - 32'd1)) != 32'd0;

    // Buddy arithmetic
    assign om1       = o_reg - 4'd1;
    assign bit_o     = IW'(1) << o_reg;
    assign split_idx = idx_reg | (IW'(1) << om1);
    assign buddy     = idx_reg ^ bit_o;
    assign user_addr = base_reg + (32'(idx_reg) << eff_c) + 32'(hdr_reg);
    assign ord_clip  = (ord_q_reg > live_top_reg) ? live_top_reg : ord_q_reg;

    // Status to controller
    always_comb
    begin
        sts.in_valid    = in_ch.valid;
        sts.opcode      = op_reg;
        sts.req_zero    = (req_reg == 31'd0);
        sts.k_fits      = (blk_bytes >= {4'b0, need_reg});
        sts.k_at_top    = (k_reg == live_top_reg);
        sts.row_any     = |row;
        sts.o_at_top    = (o_reg == live_top_reg);
        sts.o_gt_k      = (o_reg > k_reg);
        sts.free_bad    = bad_reg || !av_reg[idx_reg];
        sts.buddy_avail = free_reg[LW'(o_reg)][buddy];
        sts.o_lt_top    = (o_reg < live_top_reg);
        sts.out_free    = !out_valid_reg || out_ch.ready;
    end

    assign in_ch.ready         = cmd.in_ready;
    assign cfg.ready           = 1'b1;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.user_address = out_addr_reg;
    assign out_ch.block_order  = out_order_reg;

    // Registers, bitmaps and sequencing steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg    <= CHUNK_RST;
            hdr_reg      <= HDR_RST;
            top_reg      <= TOP_RST;
            base_reg     <= BASE_RST;
            live_top_reg <= RST_TOP;
            // only the top block is free
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                free_reg[i] <= (i == int'(RST_TOP)) ? NCH'(1) : '0;
            end
            av_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Config writes
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_CHUNK_LOG2: chunk_reg <= cfg.data[4:0];
                    REG_HEADER:     hdr_reg   <= cfg.data[7:0];
                    REG_TOP_ORDER:  top_reg   <= cfg.data[3:0];
                    REG_POOL_BASE:  base_reg  <= cfg.data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ch.ready && cmd.code != CMD_PUSH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.code)
                CMD_INIT:
                begin
                    for (int i = 0; i < ORDER_LEVELS; i++) begin
                        free_reg[i] <= (i == int'(eff_top)) ? NCH'(1) : '0;
                    end
                    av_reg         <= '0;
                    live_top_reg   <= eff_top;
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= 32'd0;
                    res_order_reg  <= eff_top;
                end
                CMD_SPLIT_START: free_reg[LW'(o_reg)][idx_reg] <= 1'b0;
                CMD_SPLIT_STEP:  free_reg[LW'(om1)][split_idx] <= 1'b1;
                CMD_ALLOC_DONE:
                begin
                    av_reg[idx_reg] <= 1'b1;
                    res_status_reg  <= ST_OK;
                    res_addr_reg    <= user_addr;
                    res_order_reg   <= k_reg;
                end
                CMD_FREE_READ:  av_reg[idx_reg] <= 1'b0;
                CMD_MERGE_STEP: free_reg[LW'(o_reg)][buddy] <= 1'b0;
                CMD_FREE_DONE:
                begin
                    free_reg[LW'(o_reg)][idx_reg] <= 1'b1;
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= user_addr;
                    res_order_reg  <= o_reg;
                end
                CMD_FAIL_SIZE:
                begin
                    res_status_reg <= ST_BAD_SIZE;
                    res_addr_reg   <= 32'd0;
                    res_order_reg  <= 4'd0;
                end
                CMD_FAIL_SPACE:
                begin
                    res_status_reg <= ST_NO_SPACE;
                    res_addr_reg   <= 32'd0;
                    res_order_reg  <= 4'd0;
                end
                CMD_FAIL_FREE:
                begin
                    res_status_reg <= ST_BAD_FREE;
                    res_addr_reg   <= 32'd0;
                    res_order_reg  <= 4'd0;
                end
                CMD_NOP:
                begin
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= 32'd0;
                    res_order_reg  <= 4'd0;
                end
                CMD_PUSH: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Payload and index registers, no reset
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                op_reg   <= in_ch.opcode;
                req_reg  <= in_ch.request_bytes;
                addr_reg <= in_ch.release_address;
            end
            CMD_SIZE_START:
            begin
                need_reg <= need_next;
                k_reg    <= 4'd0;
            end
            CMD_K_INC:        k_reg <= k_reg + 4'd1;
            CMD_SEARCH_START: o_reg <= k_reg;
            CMD_SEARCH_STEP:
            begin
                if (|row)
                begin
                    idx_reg <= enc;
                end
                else
                begin
                    o_reg <= o_reg + 4'd1;
                end
            end
            CMD_SPLIT_STEP: o_reg <= om1;
            CMD_FREE_START:
            begin
                idx_reg <= idx_full[IW-1:0];
                bad_reg <= range_bad || align_bad;
            end
            CMD_FREE_ORDER: o_reg <= ord_clip;
            CMD_MERGE_STEP:
            begin
                idx_reg <= idx_reg & ~bit_o;
                o_reg   <= o_reg + 4'd1;
            end
            CMD_PUSH:
            begin
                out_status_reg <= res_status_reg;
                out_addr_reg   <= res_addr_reg;
                out_order_reg  <= res_order_reg;
            end
            default: ;
        endcase
    end

    // Allocation order memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_ALLOC_DONE)
        begin
            ord_mem[idx_reg] <= k_reg;
        end
        ord_q_reg <= ord_mem[idx_reg];
    end

`ifndef ASSERT_OFF
    // A split step always lowers the order by one
    a_split_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_SPLIT_STEP) |=> (o_reg == $past(o_reg) - 4'd1))
        else $error("split order not decremented");

    // Merging never climbs past the latched top
    a_merge_top: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_MERGE_STEP) |-> (o_reg < live_top_reg))
        else $error("merge beyond top order");

    // A push presents a beat next cycle
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_PUSH) |=> out_valid_reg)
        else $error("pushed result not presented");
`endif

endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.code     = CMD_NONE;
        cmd.in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.code   = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.opcode)
                    OP_INIT:
                    begin
                        cmd.code   = CMD_INIT;
                        state_next = S_DONE;
                    end
                    OP_ALLOC:
                    begin
                        if (sts.req_zero)
                        begin
                            cmd.code   = CMD_FAIL_SIZE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.code   = CMD_SIZE_START;
                            state_next = S_SIZE;
                        end
                    end
                    OP_FREE:
                    begin
                        cmd.code   = CMD_FREE_START;
                        state_next = S_FCHK;
                    end
                    default:
                    begin
                        cmd.code   = CMD_NOP;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SIZE:
            begin
                if (sts.k_fits)
                begin
                    cmd.code   = CMD_SEARCH_START;
                    state_next = S_SEARCH;
                end
                else if (sts.k_at_top)
                begin
                    cmd.code   = CMD_FAIL_SIZE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.code = CMD_K_INC;
                end
            end
            S_SEARCH:
            begin
                if (sts.row_any)
                begin
                    cmd.code   = CMD_SEARCH_STEP;
                    state_next = S_SPLIT0;
                end
                else if (sts.o_at_top)
                begin
                    cmd.code   = CMD_FAIL_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.code = CMD_SEARCH_STEP;
                end
            end
            S_SPLIT0:
            begin
                cmd.code   = CMD_SPLIT_START;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (sts.o_gt_k)
                begin
                    cmd.code = CMD_SPLIT_STEP;
                end
                else
                begin
                    cmd.code   = CMD_ALLOC_DONE;
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                if (sts.free_bad)
                begin
                    cmd.code   = CMD_FAIL_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.code   = CMD_FREE_READ;
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.code   = CMD_FREE_ORDER;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (sts.o_lt_top && sts.buddy_avail)
                begin
                    cmd.code = CMD_MERGE_STEP;
                end
                else
                begin
                    cmd.code   = CMD_FREE_DONE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.code   = CMD_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    // An accepted beat is decoded next cycle
    a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.in_valid && cmd.in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");

    // A result is pushed only into a free output slot
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == CMD_PUSH) |-> sts.out_free)
        else $error("push over a pending result");

    // A finished result waits while the output is blocked
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.out_free) |=> (state_reg == S_DONE))
        else $error("result left before push");
`endif

endmodule
`default_nettype wire

// ===== hdl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Steps: init or unused opcode only decode and push; alloc also walks rounding steps, search
//   steps and split levels, free also walks merge levels; the default top order is ten.
// Throughput: one item at a time, set by the split, search and merge loops that walk
//   one order per cycle through the shared bitmap datapath.
// Reset: asynchronous; registers take their defaults, the top block is free and no
//   allocation is live.
module buddy_block_allocator #(
    parameter int MAX_CHUNKS   = bba_pkg::MAX_CHUNKS_DEF,
    parameter int ORDER_LEVELS = bba_pkg::ORDER_LEVELS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bba_in_if.sink     in_ch,
    bba_out_if.source  out_ch,
    bba_cfg_if.sink    cfg
);
    import bba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bba_dp #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .ORDER_LEVELS (ORDER_LEVELS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule
`default_nettype wire
